FILE: sv/rsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types and constants of the rotor speed mixer pipeline.
// ----------------------------------------------------------------------------
package rsm_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_HOVER_THRUST = 3'd0,
        CFG_INV_KT       = 3'd1,
        CFG_INV_KT_LX    = 3'd2,
        CFG_INV_KT_LY    = 3'd3,
        CFG_INV_KD       = 3'd4
    } t_cfg_idx;

    localparam logic [31:0] RST_HOVER_THRUST = 32'd880784;
    localparam logic [31:0] RST_INV_KT       = 32'd4084237;
    localparam logic [31:0] RST_INV_KT_LX    = 32'd31417216;
    localparam logic [31:0] RST_INV_KT_LY    = 32'd19448576;
    localparam logic [31:0] RST_INV_KD       = 32'd250882048;

    // cosine
    localparam logic [16:0] PI_Q13      = 17'd25736;
    localparam logic [16:0] HALF_PI_Q13 = 17'd12868;
    localparam logic [28:0] ONE_Q28     = 29'h1000_0000;
    localparam logic [28:0] ROUND_Q14   = 29'd8192;
    // floor(2^36/56), floor(2^36/30), floor(2^35/12)
    localparam logic [31:0] RCP_56      = 32'd1227133513;
    localparam logic [31:0] RCP_30      = 32'd2290649224;
    localparam logic [31:0] RCP_12      = 32'd2863311530;
    localparam logic [31:0] DIV_56      = 32'd56;
    localparam logic [31:0] DIV_30      = 32'd30;
    localparam logic [31:0] DIV_12      = 32'd12;
    localparam int          COS_LAT     = 12;

    // thrust divider
    localparam int          DIV_STEPS   = 4;
    localparam int          DIV_STG     = 12;
    localparam int          QUO_W       = DIV_STEPS * DIV_STG;
    localparam logic [46:0] THRUST_MAX  = {47{1'b1}};

    // mixing sums and square root
    localparam int          SUM_W       = 83;
    localparam int          SQ_STEPS    = 4;
    localparam int          SQ_STG      = 6;
    localparam logic [23:0] SPEED_MAX   = 24'hFF_FFFF;

    // pipeline map: cos, tilt product, divider setup, divider, thrust sign,
    // multiply, thrust sum, pair sums, rotor sums, classify, square root
    localparam int          ST_U        = COS_LAT + 2 + DIV_STG;
    localparam int          NSTAGE      = ST_U + 6 + SQ_STG;

    typedef struct packed {
        logic signed [31:0] tr;
        logic signed [31:0] tp;
        logic signed [31:0] ty;
    } t_tq;

    typedef struct packed {
        logic signed [33:0] thr;
        t_tq                tq;
    } t_side;

    typedef struct packed {
        logic sat;
        logic neg;
        logic zero;
    } t_dflag;

endpackage

FILE: sv/rsm_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_cos
// Twelve-stage cosine of a Q2.13 angle, Q1.14 signed result.
// ----------------------------------------------------------------------------
module rsm_cos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [15:0] o_cos
);
    import rsm_pkg::*;

    logic [COS_LAT-2:0] r_neg;
    logic [13:0] r_a;
    logic [29:0] r_x2_1, r_x2_2, r_x2_3, r_x2_4, r_x2_5, r_x2_6, r_x2_7, r_x2_8, r_x2_9;
    logic [24:0] r_q2, r_q5;
    logic [26:0] r_q8;
    logic [28:0] r_t3, r_t6, r_t9;
    logic [29:0] r_p4, r_p7;
    logic [29:0] r_p4_d, r_p7_d;
    logic [28:0] r_h10;
    logic signed [15:0] r_cos;

    logic [16:0] n_a0, n_a1, n_a2;
    logic        n_neg;
    logic [27:0] n_sq;
    logic [61:0] n_pr2, n_pr5, n_pr8;
    logic [58:0] n_pr4, n_pr7, n_pr10;
    logic [31:0] n_r3, n_r6, n_r9;
    logic [28:0] n_t3, n_t6, n_t9;
    logic [28:0] n_c;
    logic [29:0] n_rnd;

    always_comb begin
        // fold |angle| into [0, pi/2], tracking the sign flip
        n_a0  = i_angle[15] ? (17'd0 - {i_angle[15], i_angle}) : {1'b0, i_angle};
        n_neg = 1'b0;
        n_a1  = n_a0;
        if (n_a0 > PI_Q13) begin
            n_a1  = n_a0 - PI_Q13;
            n_neg = ~n_neg;
        end
        n_a2 = n_a1;
        if (n_a1 > HALF_PI_Q13) begin
            n_a2  = PI_Q13 - n_a1;
            n_neg = ~n_neg;
        end

        n_sq  = 28'({14'd0, r_a} * {14'd0, r_a});
        n_pr2 = 62'(r_x2_1) * 62'(RCP_56);
        n_r3  = 32'(r_x2_2) - 32'(r_q2) * DIV_56;
        n_t3  = ONE_Q28 - 29'(r_q2) - ((n_r3 >= DIV_56) ? 29'd1 : 29'd0);
        n_pr4 = 59'(r_x2_3) * 59'(r_t3);
        n_pr5 = 62'(r_p4) * 62'(RCP_30);
        n_r6  = 32'(r_p4_d) - 32'(r_q5) * DIV_30;
        n_t6  = ONE_Q28 - 29'(r_q5) - ((n_r6 >= DIV_30) ? 29'd1 : 29'd0);
        n_pr7 = 59'(r_x2_6) * 59'(r_t6);
        n_pr8 = 62'(r_p7) * 62'(RCP_12);
        n_r9  = 32'(r_p7_d) - 32'(r_q8) * DIV_12;
        n_t9  = ONE_Q28 - 29'(r_q8) - ((n_r9 >= DIV_12) ? 29'd1 : 29'd0);
        n_pr10 = 59'(r_x2_9) * 59'(r_t9);
        n_c   = (r_h10 >= ONE_Q28) ? 29'd0 : ONE_Q28 - r_h10;
        n_rnd = 30'(n_c) + 30'(ROUND_Q14);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg   <= {r_neg[COS_LAT-3:0], n_neg};
            r_a     <= n_a2[13:0];
            r_x2_1  <= {n_sq, 2'b00};
            r_x2_2  <= r_x2_1;
            r_q2    <= n_pr2[60:36];
            r_x2_3  <= r_x2_2;
            r_t3    <= n_t3;
            r_x2_4  <= r_x2_3;
            r_p4    <= n_pr4[57:28];
            r_x2_5  <= r_x2_4;
            r_p4_d  <= r_p4;
            r_q5    <= n_pr5[60:36];
            r_x2_6  <= r_x2_5;
            r_t6    <= n_t6;
            r_x2_7  <= r_x2_6;
            r_p7    <= n_pr7[57:28];
            r_x2_8  <= r_x2_7;
            r_p7_d  <= r_p7;
            r_q8    <= n_pr8[61:35];
            r_x2_9  <= r_x2_8;
            r_t9    <= n_t9;
            r_h10   <= n_pr10[57:29];
            r_cos   <= r_neg[COS_LAT-2] ? (16'sd0 - $signed({1'b0, n_rnd[28:14]}))
                                        : $signed({1'b0, n_rnd[28:14]});
        end
    end

    assign o_cos = r_cos;

endmodule

FILE: sv/quadrotor_rotor_speed_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_rotor_speed_mixer
// X-layout rotor mixer: tilt-compensated thrust plus torques to four rotor
// speeds through a fixed-latency pipeline.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// in       to block   i_in_valid / o_in_ready     thrust, torques, angles
// out      from block o_out_valid / i_out_ready   four speeds, clip mask
// cfg      to block   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One command per cycle unless the output stalls; the pipeline depth is set
// by the cosine chain, the 48-step thrust divider (4 steps a stage)
// and the 24-step square root (4 steps a stage).
// Synchronous active-low reset clears the valid bits and restores registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quadrotor_rotor_speed_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_thrust_offset,
    input  logic signed [31:0] i_roll_torque,
    input  logic signed [31:0] i_pitch_torque,
    input  logic signed [31:0] i_yaw_torque,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_rotor_speed_0,
    output logic [23:0]        o_rotor_speed_1,
    output logic [23:0]        o_rotor_speed_2,
    output logic [23:0]        o_rotor_speed_3,
    output logic [3:0]         o_clipped_mask,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  rsm_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rsm_pkg::*;

    logic en;
    logic [NSTAGE-1:0] r_vld;

    logic [31:0] r_hover, r_kt, r_lx, r_ly, r_kd;

    assign o_cfg_ready = 1'b1;
    assign en          = ~r_vld[NSTAGE-1] | i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_hover <= RST_HOVER_THRUST;
            r_kt    <= RST_INV_KT;
            r_lx    <= RST_INV_KT_LX;
            r_ly    <= RST_INV_KT_LY;
            r_kd    <= RST_INV_KD;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTAGE-2:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HOVER_THRUST: r_hover <= i_cfg_data;
                    CFG_INV_KT:       r_kt    <= i_cfg_data;
                    CFG_INV_KT_LX:    r_lx    <= i_cfg_data;
                    CFG_INV_KT_LY:    r_ly    <= i_cfg_data;
                    CFG_INV_KD:       r_kd    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- cosines, thrust and torques ride alongside
    logic signed [15:0] cos_r, cos_p;

    rsm_cos u_cos_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_roll_angle),
        .o_cos   (cos_r)
    );

    rsm_cos u_cos_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_pitch_angle),
        .o_cos   (cos_p)
    );

    t_side r_side [COS_LAT];
    t_side n_side;

    always_comb begin
        n_side.thr   = $signed({2'b00, r_hover}) + $signed({{2{i_thrust_offset[31]}},
                                                            i_thrust_offset});
        n_side.tq.tr = i_roll_torque;
        n_side.tq.tp = i_pitch_torque;
        n_side.tq.ty = i_yaw_torque;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < COS_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- tilt product, then divider setup
    logic signed [29:0] r_cp;
    logic [33:0]        r_mt_p, r_mt_q;
    logic               r_tneg, r_tzero;
    t_tq                r_tq_p, r_tq_q;
    logic [28:0]        r_mc;
    logic [28:0]        r_rem_q;
    t_dflag             r_fl_q;

    logic signed [31:0] n_cp;
    logic [28:0]        n_mc;

    always_comb begin
        n_cp = cos_r * cos_p;
        n_mc = r_cp[29] ? 29'(30'd0 - r_cp) : r_cp[28:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cp    <= n_cp[29:0];
            r_mt_p  <= r_side[COS_LAT-1].thr[33] ? 34'(34'd0 - r_side[COS_LAT-1].thr)
                                                : r_side[COS_LAT-1].thr;
            r_tneg  <= r_side[COS_LAT-1].thr[33];
            r_tzero <= (r_side[COS_LAT-1].thr == 34'sd0);
            r_tq_p  <= r_side[COS_LAT-1].tq;

            r_mc        <= n_mc;
            r_mt_q      <= r_mt_p;
            r_rem_q     <= {15'd0, r_mt_p[33:20]};
            r_fl_q.sat  <= ({14'd0, r_mt_p} >= {n_mc, 19'd0});
            r_fl_q.neg  <= r_tneg ^ r_cp[29];
            r_fl_q.zero <= r_tzero;
            r_tq_q      <= r_tq_p;
        end
    end

    // ---------------- thrust divider: (mt << 28) / mc, restoring
    logic [28:0]       r_dv_rem [DIV_STG];
    logic [QUO_W-1:0]  r_dv_q   [DIV_STG];
    logic [33:0]       r_dv_mt  [DIV_STG];
    logic [28:0]       r_dv_mc  [DIV_STG];
    t_dflag            r_dv_fl  [DIV_STG];
    t_tq               r_dv_tq  [DIV_STG];

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        logic [28:0]      in_rem;
        logic [QUO_W-1:0] in_q;
        logic [33:0]      in_mt;
        logic [28:0]      in_mc;
        t_dflag           in_fl;
        t_tq              in_tq;
        logic [28:0]      n_rem;
        logic [QUO_W-1:0] n_q;
        logic [29:0]      n_sh;
        logic [61:0]      num;

        if (g == 0) begin : g_first
            assign in_rem = r_rem_q;
            assign in_q   = '0;
            assign in_mt  = r_mt_q;
            assign in_mc  = r_mc;
            assign in_fl  = r_fl_q;
            assign in_tq  = r_tq_q;
        end else begin : g_next
            assign in_rem = r_dv_rem[g-1];
            assign in_q   = r_dv_q[g-1];
            assign in_mt  = r_dv_mt[g-1];
            assign in_mc  = r_dv_mc[g-1];
            assign in_fl  = r_dv_fl[g-1];
            assign in_tq  = r_dv_tq[g-1];
        end

        always_comb begin
            num   = {in_mt, 28'd0};
            n_rem = in_rem;
            n_q   = in_q;
            n_sh  = '0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                n_sh = {n_rem, num[QUO_W-1-g*DIV_STEPS-k]};
                if (n_sh >= {1'b0, in_mc}) begin
                    n_sh = n_sh - {1'b0, in_mc};
                    n_q  = {n_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_q  = {n_q[QUO_W-2:0], 1'b0};
                end
                n_rem = n_sh[28:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[g] <= n_rem;
                r_dv_q[g]   <= n_q;
                r_dv_mt[g]  <= in_mt;
                r_dv_mc[g]  <= in_mc;
                r_dv_fl[g]  <= in_fl;
                r_dv_tq[g]  <= in_tq;
            end
        end
    end

    // ---------------- signed compensated thrust
    logic [46:0]        n_mag;
    logic signed [47:0] n_u, r_u;
    t_tq                r_tq_u;

    always_comb begin
        n_mag = r_dv_fl[DIV_STG-1].sat ? THRUST_MAX : r_dv_q[DIV_STG-1][46:0];
        if (r_dv_fl[DIV_STG-1].zero) begin
            n_u = '0;
        end else if (r_dv_fl[DIV_STG-1].neg) begin
            n_u = 48'sd0 - $signed({1'b0, n_mag});
        end else begin
            n_u = $signed({1'b0, n_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u    <= n_u;
            r_tq_u <= r_dv_tq[DIV_STG-1];
        end
    end

    // ---------------- products
    logic [55:0]        r_pl;
    logic signed [56:0] r_ph;
    logic signed [64:0] r_pr, r_pp, r_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl <= {32'd0, r_u[23:0]} * {24'd0, r_kt};
            r_ph <= $signed(r_u[47:24]) * $signed({1'b0, r_kt});
            r_pr <= r_tq_u.tr * $signed({1'b0, r_lx});
            r_pp <= r_tq_u.tp * $signed({1'b0, r_ly});
            r_py <= r_tq_u.ty * $signed({1'b0, r_kd});
        end
    end

    // ---------------- thrust term, pair sums, rotor sums
    logic [SUM_W-1:0] r_ua, r_ra, r_pa, r_ya;
    logic [SUM_W-1:0] r_uy_p, r_uy_m, r_rp_p, r_rp_m;
    logic [SUM_W-1:0] r_rot [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ua <= {{(SUM_W-81){r_ph[56]}}, r_ph, 24'd0} + {27'd0, r_pl};
            r_ra <= {{(SUM_W-65){r_pr[64]}}, r_pr};
            r_pa <= {{(SUM_W-65){r_pp[64]}}, r_pp};
            r_ya <= {{(SUM_W-65){r_py[64]}}, r_py};

            r_uy_p <= r_ua + r_ya;
            r_uy_m <= r_ua - r_ya;
            r_rp_p <= r_ra + r_pa;
            r_rp_m <= r_ra - r_pa;

            r_rot[0] <= r_uy_p - r_rp_p;
            r_rot[1] <= r_uy_p + r_rp_p;
            r_rot[2] <= r_uy_m + r_rp_m;
            r_rot[3] <= r_uy_m - r_rp_m;
        end
    end

    // ---------------- classify and square root, one lane per rotor
    logic [3:0]  r_clip, r_over;
    logic [3:0]  r_sq_clip [SQ_STG];
    logic [3:0]  r_sq_over [SQ_STG];
    logic [47:0] r_n [4];
    logic [23:0] root_out [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_clip[i] <= r_rot[i][SUM_W-1] | (r_rot[i] == '0);
                r_over[i] <= ~r_rot[i][SUM_W-1] & (|r_rot[i][SUM_W-2:48]);
                r_n[i]    <= r_rot[i][47:0];
            end
            r_sq_clip[0] <= r_clip;
            r_sq_over[0] <= r_over;
            for (int g = 1; g < SQ_STG; g++) begin
                r_sq_clip[g] <= r_sq_clip[g-1];
                r_sq_over[g] <= r_sq_over[g-1];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [23:0] r_root [SQ_STG];
        logic [25:0] r_rem  [SQ_STG];
        logic [47:0] r_sn   [SQ_STG];

        for (genvar g = 0; g < SQ_STG; g++) begin : g_sq
            logic [23:0] in_root, n_root;
            logic [25:0] in_rem,  n_rem;
            logic [47:0] in_n;
            logic [26:0] n_sh, n_trial;

            if (g == 0) begin : g_first
                assign in_root = '0;
                assign in_rem  = '0;
                assign in_n    = r_n[l];
            end else begin : g_next
                assign in_root = r_root[g-1];
                assign in_rem  = r_rem[g-1];
                assign in_n    = r_sn[g-1];
            end

            always_comb begin
                n_root  = in_root;
                n_rem   = in_rem;
                n_sh    = '0;
                n_trial = '0;
                for (int k = 0; k < SQ_STEPS; k++) begin
                    n_sh    = {n_rem[24:0], in_n[2*(23-g*SQ_STEPS-k)+1],
                               in_n[2*(23-g*SQ_STEPS-k)]};
                    n_trial = {1'b0, n_root, 2'b01};
                    if (n_sh >= n_trial) begin
                        n_sh   = n_sh - n_trial;
                        n_root = {n_root[22:0], 1'b1};
                    end else begin
                        n_root = {n_root[22:0], 1'b0};
                    end
                    n_rem = n_sh[25:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_root[g] <= n_root;
                    r_rem[g]  <= n_rem;
                    r_sn[g]   <= in_n;
                end
            end
        end

        assign root_out[l] = r_sq_clip[SQ_STG-1][l] ? 24'd0 :
                             r_sq_over[SQ_STG-1][l] ? SPEED_MAX : r_root[SQ_STG-1];
    end

    assign o_rotor_speed_0 = root_out[0];
    assign o_rotor_speed_1 = root_out[1];
    assign o_rotor_speed_2 = root_out[2];
    assign o_rotor_speed_3 = root_out[3];
    assign o_clipped_mask  = r_sq_clip[SQ_STG-1];

    // ---------------- checks
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted command did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_thrust_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_U] |-> r_u != {1'b1, 47'd0})
        else $error("compensated thrust beyond its saturation bound");

    a_clip_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_clipped_mask & r_sq_over[SQ_STG-1]) == 4'd0)
        else $error("rotor flagged both clipped and saturated");

endmodule

FILE: verif/quadrotor_rotor_speed_mixer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_rotor_speed_mixer_test
// Self-checking bench: a directed table and then random commands are driven
// through the mixer under several idle and stall patterns and register settings;
// each result is compared with a fixed row answer or a bit-exact speed predictor.
// ----------------------------------------------------------------------------
module quadrotor_rotor_speed_mixer_test;
    import rsm_pkg::*;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1530;

    typedef struct packed {
        logic signed [31:0] thr;
        logic signed [31:0] tr;
        logic signed [31:0] tp;
        logic signed [31:0] ty;
        logic signed [15:0] ra;
        logic signed [15:0] pa;
    } t_cmd;

    typedef struct packed {
        logic [23:0] s0;
        logic [23:0] s1;
        logic [23:0] s2;
        logic [23:0] s3;
        logic [3:0]  mask;
    } t_speeds;

    typedef struct {
        t_cmd    cmd;
        bit      fixed;
        t_speeds want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_thrust_offset;
    logic signed [31:0] i_roll_torque;
    logic signed [31:0] i_pitch_torque;
    logic signed [31:0] i_yaw_torque;
    logic signed [15:0] i_roll_angle;
    logic signed [15:0] i_pitch_angle;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [23:0]        o_rotor_speed_0;
    logic [23:0]        o_rotor_speed_1;
    logic [23:0]        o_rotor_speed_2;
    logic [23:0]        o_rotor_speed_3;
    logic [3:0]         o_clipped_mask;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [31:0]        i_cfg_data;

    quadrotor_rotor_speed_mixer dut (.*);

    // predictor copy of the registers
    logic [31:0] hover_q16;
    logic [31:0] kt_rcp;
    logic [31:0] ktlx_rcp;
    logic [31:0] ktly_rcp;
    logic [31:0] kd_rcp;

    t_speeds speeds_due[$];
    int      n_errors;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      recv_hold;
    int      hold_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic signed [31:0] cos_q14(logic signed [15:0] ang);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] h;
        logic [63:0] c;
        logic [63:0] q;
        bit          neg;
        a   = (ang < 0) ? 64'(-int'(ang)) : 64'(int'(ang));
        neg = 1'b0;
        if (a > 64'd25736) begin
            a   = a - 64'd25736;
            neg = ~neg;
        end
        if (a > 64'd12868) begin
            a   = 64'd25736 - a;
            neg = ~neg;
        end
        x2 = a * a * 64'd4;
        t  = (64'd1 << 28) - x2 / 64'd56;
        t  = (64'd1 << 28) - ((x2 * t) >> 28) / 64'd30;
        t  = (64'd1 << 28) - ((x2 * t) >> 28) / 64'd12;
        h  = ((x2 * t) >> 28) / 64'd2;
        c  = (h >= (64'd1 << 28)) ? 64'd0 : (64'd1 << 28) - h;
        q  = (c + 64'd8192) >> 14;
        return neg ? -32'(q) : 32'(q);
    endfunction

    function automatic t_speeds mix_speeds(t_cmd cmd);
        t_speeds          r;
        logic signed [63:0] cp;
        logic signed [63:0] thrust;
        logic signed [63:0] u;
        logic [63:0]        mt;
        logic [63:0]        mc;
        logic [63:0]        q;
        logic signed [127:0] tu;
        logic signed [127:0] tr;
        logic signed [127:0] tp;
        logic signed [127:0] ty;
        logic signed [127:0] sq [4];
        logic [23:0]        sp [4];
        bit                 neg;
        cp     = 64'(cos_q14(cmd.ra)) * 64'(cos_q14(cmd.pa));
        thrust = $signed({32'd0, hover_q16}) + 64'(cmd.thr);
        if (thrust == 0) begin
            u = 0;
        end else begin
            neg = (thrust < 0) != (cp < 0);
            mt  = (thrust < 0) ? -thrust : thrust;
            mc  = (cp < 0) ? -cp : cp;
            if (mc == 0) begin
                q   = (64'd1 << 47) - 1;
                neg = thrust < 0;
            end else begin
                q = (mt << 28) / mc;
            end
            if (q > (64'd1 << 47) - 1) q = (64'd1 << 47) - 1;
            u = neg ? -$signed(q) : $signed(q);
        end
        tu = 128'(u) * $signed({96'd0, kt_rcp});
        tr = 128'(cmd.tr) * $signed({96'd0, ktlx_rcp});
        tp = 128'(cmd.tp) * $signed({96'd0, ktly_rcp});
        ty = 128'(cmd.ty) * $signed({96'd0, kd_rcp});
        sq[0] = tu - tr - tp + ty;
        sq[1] = tu + tr + tp + ty;
        sq[2] = tu + tr - tp - ty;
        sq[3] = tu - tr + tp - ty;
        r.mask = '0;
        for (int i = 0; i < 4; i++) begin
            if (sq[i] <= 0) begin
                sp[i]     = '0;
                r.mask[i] = 1'b1;
            end else if (sq[i] >= (128'sd1 <<< 48)) begin
                sp[i] = 24'hFF_FFFF;
            end else begin
                sp[i] = 24'($floor($sqrt(real'(sq[i]))));
                // correct any rounding of the real square root
                while (64'(sp[i]) * 64'(sp[i]) > 64'(sq[i])) sp[i]--;
                while ((64'(sp[i]) + 1) * (64'(sp[i]) + 1) <= 64'(sq[i])) sp[i]++;
            end
        end
        r.s0 = sp[0];
        r.s1 = sp[1];
        r.s2 = sp[2];
        r.s3 = sp[3];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        n_errors++;
    endtask

    // result check at the rising edge
    always @(posedge i_clk) begin
        t_speeds w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (speeds_due.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                n_errors++;
            end else begin
                w = speeds_due.pop_front();
                if (o_rotor_speed_0 !== w.s0) report_mismatch("speed0", o_rotor_speed_0, w.s0);
                if (o_rotor_speed_1 !== w.s1) report_mismatch("speed1", o_rotor_speed_1, w.s1);
                if (o_rotor_speed_2 !== w.s2) report_mismatch("speed2", o_rotor_speed_2, w.s2);
                if (o_rotor_speed_3 !== w.s3) report_mismatch("speed3", o_rotor_speed_3, w.s3);
                if (o_clipped_mask !== w.mask)
                    report_mismatch("mask", 24'(o_clipped_mask), 24'(w.mask));
            end
        end
    end

    // receiver ready, updated at the falling edge
    always @(negedge i_clk) begin
        if (recv_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("quadrotor_rotor_speed_mixer_test failed");
            $finish;
        end
    end

    // hold off the receiver for a counted stretch
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            if (hold_cycles == 0) recv_hold <= 1'b0;
        end
    end

    // valid stays up after a transfer until the next command or an idle cycle
    task automatic send_cmd(t_cmd cmd, t_speeds want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_thrust_offset <= cmd.thr;
        i_roll_torque   <= cmd.tr;
        i_pitch_torque  <= cmd.tp;
        i_yaw_torque    <= cmd.ty;
        i_roll_angle    <= cmd.ra;
        i_pitch_angle   <= cmd.pa;
        speeds_due.push_back(want);
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (speeds_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HOVER_THRUST: hover_q16 = val;
            CFG_INV_KT:       kt_rcp    = val;
            CFG_INV_KT_LX:    ktlx_rcp  = val;
            CFG_INV_KT_LY:    ktly_rcp  = val;
            CFG_INV_KD:       kd_rcp    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(51472)) - 25736);
            1: return 16'($signed($urandom_range(2000)) - 1000);
            2: return ($urandom_range(1) ? 16'sd12868 : -16'sd12868) +
                      16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(262144)) - 131072);
            2: return 32'($signed($urandom_range(8388608)) - 4194304);
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    task automatic run_random(int n);
        t_cmd cmd;
        for (int i = 0; i < n; i++) begin
            cmd.thr = rand_word();
            cmd.tr  = rand_word();
            cmd.tp  = rand_word();
            cmd.ty  = rand_word();
            cmd.ra  = rand_angle();
            cmd.pa  = rand_angle();
            send_cmd(cmd, mix_speeds(cmd));
        end
    endtask

    initial begin
        t_row rows[$];
        t_row row;
        int   per;
        n_errors        = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        recv_hold       = 1'b0;
        hold_cycles     = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_out_ready     = 1'b1;
        i_thrust_offset = '0;
        i_roll_torque   = '0;
        i_pitch_torque  = '0;
        i_yaw_torque    = '0;
        i_roll_angle    = '0;
        i_pitch_angle   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_HOVER_THRUST;
        i_cfg_data      = '0;
        hover_q16       = RST_HOVER_THRUST;
        kt_rcp          = RST_INV_KT;
        ktlx_rcp        = RST_INV_KT_LX;
        ktly_rcp        = RST_INV_KT_LY;
        kd_rcp          = RST_INV_KD;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; fixed rows carry their answer
        // thrust cancels hover: all rotors clip
        rows.push_back('{'{-32'sd880784, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 4'hF}});
        // zero tilt product with positive thrust: every rotor saturates
        rows.push_back('{'{0, 0, 0, 0, 16'sd12868, 0}, 1'b1,
                         '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 4'h0}});
        // zero tilt product with negative thrust: all clip
        rows.push_back('{'{-32'sd2000000, 0, 0, 0, 0, -16'sd12868}, 1'b1,
                         '{0, 0, 0, 0, 4'hF}});
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{32'sh7FFF_FFFF, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{32'sh8000_0000, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 32'sh7FFF_FFFF, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 32'sh8000_0000, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 32'sh7FFF_FFFF, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 32'sh8000_0000, 0, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 32'sh7FFF_FFFF, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 32'sh8000_0000, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 65536, -65536, 32768, 16'sd25736, 16'sd25736}, 1'b0,
                         '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 0, -16'sd25736, 16'sd1000}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 0, 16'sh7FFF, 16'sh8000}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 0, 16'sh8000, 16'sh7FFF}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 0, 16'sd20000, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{12345, 0, 0, 0, 16'sd12867, 16'sd12869}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 300000, 0, 0, 16'sd500, -16'sd700}, 1'b0, '{0, 0, 0, 0, 0}});
        rows.push_back('{'{0, 0, -300000, 200000, 0, 0}, 1'b0, '{0, 0, 0, 0, 0}});
        foreach (rows[i]) begin
            row = rows[i];
            send_cmd(row.cmd, row.fixed ? row.want : mix_speeds(row.cmd));
        end
        drain_results();

        // idle and stall phases under the reset registers
        per = N_RANDOM / 11;
        send_idle_pct = 71; recv_stall_pct = 0;  run_random(per);
        send_idle_pct = 0;  recv_stall_pct = 71; run_random(per);
        send_idle_pct = 7;  recv_stall_pct = 7;  run_random(per);

        // long receiver hold while commands keep coming, to back up the pipe
        send_idle_pct = 0; recv_stall_pct = 0;
        recv_hold   = 1'b1;
        hold_cycles = 200;
        run_random(per);
        // pause the sender until everything has come out
        drain_results();

        // extreme register values, all zeros first
        write_reg(CFG_HOVER_THRUST, 32'd0);
        write_reg(CFG_INV_KT,       32'd0);
        write_reg(CFG_INV_KT_LX,    32'd0);
        write_reg(CFG_INV_KT_LY,    32'd0);
        write_reg(CFG_INV_KD,       32'd0);
        run_random(per / 2);
        drain_results();

        write_reg(CFG_HOVER_THRUST, 32'hFFFF_FFFF);
        write_reg(CFG_INV_KT,       32'hFFFF_FFFF);
        write_reg(CFG_INV_KT_LX,    32'hFFFF_FFFF);
        write_reg(CFG_INV_KT_LY,    32'hFFFF_FFFF);
        write_reg(CFG_INV_KD,       32'hFFFF_FFFF);
        send_idle_pct = 71; recv_stall_pct = 71;
        run_random(per / 2);
        drain_results();

        // small coefficients keep the squared speeds in range
        write_reg(CFG_HOVER_THRUST, 32'd65536);
        write_reg(CFG_INV_KT,       32'd256);
        write_reg(CFG_INV_KT_LX,    32'd512);
        write_reg(CFG_INV_KT_LY,    32'd300);
        write_reg(CFG_INV_KD,       32'd1000);
        send_idle_pct = 7; recv_stall_pct = 7;
        run_random(per);
        drain_results();

        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_HOVER_THRUST, $urandom);
            write_reg(CFG_INV_KT,       $urandom >> $urandom_range(31));
            write_reg(CFG_INV_KT_LX,    $urandom >> $urandom_range(31));
            write_reg(CFG_INV_KT_LY,    $urandom >> $urandom_range(31));
            write_reg(CFG_INV_KD,       $urandom >> $urandom_range(31));
            send_idle_pct  = (k % 2) ? 71 : 0;
            recv_stall_pct = (k > 1) ? 71 : 7;
            run_random(per);
            drain_results();
        end

        write_reg(CFG_HOVER_THRUST, RST_HOVER_THRUST);
        write_reg(CFG_INV_KT,       RST_INV_KT);
        write_reg(CFG_INV_KT_LX,    RST_INV_KT_LX);
        write_reg(CFG_INV_KT_LY,    RST_INV_KT_LY);
        write_reg(CFG_INV_KD,       RST_INV_KD);
        send_idle_pct = 0; recv_stall_pct = 0;
        run_random(N_RANDOM - 9 * per - 2 * (per / 2));
        drain_results();

        if (n_errors == 0) $display("quadrotor_rotor_speed_mixer_test passed");
        else $display("quadrotor_rotor_speed_mixer_test failed");
        $finish;
    end
endmodule
